// ===== design/tdss_pkg.sv =====
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types, register indexes and saturation helpers for the tank drive
// setpoint shaper.
// ----------------------------------------------------------------------------
package tdss_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TURN_SCALE  = 2'd0;
  localparam logic [1:0] REG_SPEED_ALPHA = 2'd1;
  localparam logic [1:0] REG_HIGH_SPEED  = 2'd2;
  localparam logic [1:0] REG_LOW_SPEED   = 2'd3;

  // register reset values
  localparam logic [15:0] TURN_SCALE_RST  = 16'd16384;
  localparam logic [15:0] SPEED_ALPHA_RST = 16'd6554;

  // filtered speed limits, Q8.16
  localparam logic [23:0] SPEED_DEADBAND = 24'd3277;
  localparam logic [23:0] FSPEED_MAX     = 24'hFFFFFF;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUBE,
    ST_MIX,
    ST_SCALE,
    ST_OUT
  } state_e;

  // per-cycle step strobes from the sequencer
  typedef struct packed {
    logic load;
    logic cube;
    logic mix;
    logic scale;
  } step_t;

  // saturate to Q1.15
  function automatic logic signed [15:0] sat_q15(input logic signed [21:0] x);
    logic signed [15:0] r;
    if (x > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // saturate to the 17-bit setpoint range
  function automatic logic signed [16:0] sat_sp(input logic signed [18:0] x);
    logic signed [16:0] r;
    if (x > 19'sd65535) begin
      r = 17'sh0FFFF;
    end else if (x < -19'sd65536) begin
      r = 17'sh10000;
    end else begin
      r = x[16:0];
    end
    return r;
  endfunction

endpackage

// ===== design/tdss_lane.sv =====
// ----------------------------------------------------------------------------
// tdss_lane
// One stick lane: squares the stick on load, multiplies by the stick again
// and rounds the cube back to Q1.15.
// ----------------------------------------------------------------------------
module tdss_lane (
  input  logic                 clk_i,
  input  tdss_pkg::step_t      step_i,
  input  logic signed [15:0]   stick_i,
  output logic signed [15:0]   cube_o
);

  logic signed [15:0] stick_q;
  logic        [30:0] sq_q;
  logic signed [47:0] cub_q;
  logic signed [31:0] sq_full;
  logic signed [47:0] cub_rnd;

  assign sq_full = stick_i * stick_i;

  // square on load, cube on the next step
  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      stick_q <= stick_i;
      sq_q    <= sq_full[30:0];
    end
    if (step_i.cube) begin
      cub_q <= $signed({1'b0, sq_q}) * stick_q;
    end
  end

  // round half up, drop 30 fraction bits
  assign cub_rnd = cub_q + 48'sd536870912;
  assign cube_o  = cub_rnd[45:30];

endmodule

// ===== design/tdss_speed_filter.sv =====
// ----------------------------------------------------------------------------
// tdss_speed_filter
// Exponential low-pass on the selected top speed with a deadband near zero.
// ----------------------------------------------------------------------------
module tdss_speed_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tdss_pkg::step_t step_i,
  input  logic            gear_i,
  input  logic [15:0]     high_speed_i,
  input  logic [15:0]     low_speed_i,
  input  logic [15:0]     alpha_i,
  output logic [23:0]     speed_o
);

  logic        [23:0] f_q;
  logic        [23:0] f_d;
  logic signed [41:0] prod_q;
  logic        [15:0] top;
  logic signed [24:0] delta;
  logic signed [41:0] prod;
  logic signed [41:0] prod_rnd;
  logic signed [25:0] stp;
  logic signed [26:0] nf;

  // error times coefficient
  assign top   = gear_i ? high_speed_i : low_speed_i;
  assign delta = $signed({1'b0, top, 8'b0}) - $signed({1'b0, f_q});
  assign prod  = delta * $signed({1'b0, alpha_i});

  // rounded step and clamp to 24 bits
  assign prod_rnd = prod_q + 42'sd32768;
  assign stp      = prod_rnd[41:16];
  assign nf       = $signed({3'b0, f_q}) + 27'(stp);

  always_comb begin
    if (nf < 27'sd0) begin
      f_d = '0;
    end else if (nf > $signed({3'b0, tdss_pkg::FSPEED_MAX})) begin
      f_d = tdss_pkg::FSPEED_MAX;
    end else begin
      f_d = nf[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      prod_q <= prod;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (step_i.cube) begin
      f_q <= f_d;
    end
  end

  // deadband
  assign speed_o = (f_q < tdss_pkg::SPEED_DEADBAND) ? '0 : f_q;

endmodule

// ===== design/tdss_merge.sv =====
// ----------------------------------------------------------------------------
// tdss_merge
// Mixes the two cubed sticks into left and right drive values and scales
// them by the filtered top speed into Q8.8 setpoints.
// ----------------------------------------------------------------------------
module tdss_merge (
  input  logic                 clk_i,
  input  tdss_pkg::step_t      step_i,
  input  logic signed [15:0]   cube_l_i,
  input  logic signed [15:0]   cube_r_i,
  input  logic        [15:0]   turn_scale_i,
  input  logic        [23:0]   speed_i,
  output logic signed [16:0]   left_o,
  output logic signed [16:0]   right_o
);

  logic signed [16:0] sum;
  logic signed [16:0] diff;
  logic signed [33:0] turn_prod;
  logic signed [30:0] mean_q;
  logic signed [34:0] dd_q;
  logic signed [36:0] vl;
  logic signed [36:0] vr;
  logic signed [15:0] ml;
  logic signed [15:0] mr;
  logic signed [40:0] lp_q;
  logic signed [40:0] rp_q;
  logic signed [40:0] lrnd;
  logic signed [40:0] rrnd;
  logic signed [17:0] lt;
  logic signed [17:0] rt;

  // mean and scaled difference at Q.30
  assign sum       = 17'(cube_l_i) + 17'(cube_r_i);
  assign diff      = 17'(cube_l_i) - 17'(cube_r_i);
  assign turn_prod = diff * $signed({1'b0, turn_scale_i});

  // mix, round and saturate to Q1.15
  assign vl = 37'(mean_q) + 37'(dd_q) + 37'sd16384;
  assign vr = 37'(mean_q) - 37'(dd_q) + 37'sd16384;
  assign ml = tdss_pkg::sat_q15(vl[36:15]);
  assign mr = tdss_pkg::sat_q15(vr[36:15]);

  always_ff @(posedge clk_i) begin
    if (step_i.mix) begin
      mean_q <= $signed({sum, 14'b0});
      dd_q   <= $signed({turn_prod, 1'b0});
    end
    if (step_i.scale) begin
      lp_q <= ml * $signed({1'b0, speed_i});
      rp_q <= mr * $signed({1'b0, speed_i});
    end
  end

  // round to Q8.8, negate right, saturate
  assign lrnd    = lp_q + 41'sd4194304;
  assign rrnd    = rp_q + 41'sd4194304;
  assign lt      = lrnd[40:23];
  assign rt      = rrnd[40:23];
  assign left_o  = tdss_pkg::sat_sp(19'(lt));
  assign right_o = tdss_pkg::sat_sp(-19'(rt));

endmodule

// ===== design/tank_drive_setpoint_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// tank_drive_setpoint_shaper_unit
// Tank drive joystick shaping: cube, mix, top speed low-pass, Q8.8 setpoints.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An accepted item is squared on the accepting
// edge, then cubed, mixed and scaled in the CUBE, MIX and SCALE states, and is
// loaded into the output register in the OUT state, which waits while a held
// result is stalled. The block takes one item at a time and only returns to
// idle on the output load, so it takes no new item before the last one is
// loaded; the sequencer walks both stick lanes and the shared merge stage
// through their multiplier steps. A result waiting in the output register does
// not block acceptance of the next item. Configuration writes are taken at any
// time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module tank_drive_setpoint_shaper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  left_stick_i,
  input  logic signed [15:0]  right_stick_i,
  input  logic                high_gear_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [16:0]  left_setpoint_o,
  output logic signed [16:0]  right_setpoint_o,
  output logic                shift_up_o,
  output logic                shift_down_o
);

  tdss_pkg::state_e   state_q, state_d;
  tdss_pkg::step_t    step;
  logic               out_load;
  logic               in_accept;

  logic [15:0]        turn_scale_q;
  logic [15:0]        speed_alpha_q;
  logic [15:0]        high_speed_q;
  logic [15:0]        low_speed_q;

  logic               gear_q;
  logic               out_valid_q;
  logic signed [16:0] left_q;
  logic signed [16:0] right_q;
  logic               shift_up_q;

  logic signed [15:0] cube_l;
  logic signed [15:0] cube_r;
  logic [23:0]        speed;
  logic signed [16:0] left_sp;
  logic signed [16:0] right_sp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_scale_q  <= tdss_pkg::TURN_SCALE_RST;
      speed_alpha_q <= tdss_pkg::SPEED_ALPHA_RST;
      high_speed_q  <= '0;
      low_speed_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdss_pkg::REG_TURN_SCALE:  turn_scale_q  <= cfg_data_i;
        tdss_pkg::REG_SPEED_ALPHA: speed_alpha_q <= cfg_data_i;
        tdss_pkg::REG_HIGH_SPEED:  high_speed_q  <= cfg_data_i;
        tdss_pkg::REG_LOW_SPEED:   low_speed_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != tdss_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and step strobes
  always_comb begin
    state_d  = state_q;
    step     = '0;
    out_load = 1'b0;
    unique case (state_q)
      tdss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          step.load = 1'b1;
          state_d   = tdss_pkg::ST_CUBE;
        end
      end
      tdss_pkg::ST_CUBE: begin
        step.cube = 1'b1;
        state_d   = tdss_pkg::ST_MIX;
      end
      tdss_pkg::ST_MIX: begin
        step.mix = 1'b1;
        state_d  = tdss_pkg::ST_SCALE;
      end
      tdss_pkg::ST_SCALE: begin
        step.scale = 1'b1;
        state_d    = tdss_pkg::ST_OUT;
      end
      tdss_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tdss_pkg::ST_IDLE;
        end
      end
      default: state_d = tdss_pkg::ST_IDLE;
    endcase
  end

  // gear of the item in flight
  always_ff @(posedge clk_i) begin
    if (step.load) begin
      gear_q <= high_gear_i;
    end
  end

  // stick lanes
  tdss_lane u_lane_l (
    .clk_i   (clk_i),
    .step_i  (step),
    .stick_i (left_stick_i),
    .cube_o  (cube_l)
  );

  tdss_lane u_lane_r (
    .clk_i   (clk_i),
    .step_i  (step),
    .stick_i (right_stick_i),
    .cube_o  (cube_r)
  );

  // top speed filter
  tdss_speed_filter u_filter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .gear_i       (high_gear_i),
    .high_speed_i (high_speed_q),
    .low_speed_i  (low_speed_q),
    .alpha_i      (speed_alpha_q),
    .speed_o      (speed)
  );

  // mix and scale
  tdss_merge u_merge (
    .clk_i        (clk_i),
    .step_i       (step),
    .cube_l_i     (cube_l),
    .cube_r_i     (cube_r),
    .turn_scale_i (turn_scale_q),
    .speed_i      (speed),
    .left_o       (left_sp),
    .right_o      (right_sp)
  );

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q     <= left_sp;
      right_q    <= right_sp;
      shift_up_q <= gear_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_setpoint_o  = left_q;
  assign right_setpoint_o = right_q;
  assign shift_up_o       = shift_up_q;
  assign shift_down_o     = !shift_up_q;

  // an accepted beat keeps the input side stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  // a result only appears out of the output state
  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tdss_pkg::ST_OUT))
    else $error("output valid rose outside output state");

  // filtered speed used is either zero or above the deadband
  a_deadband: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed != '0) |-> (speed >= tdss_pkg::SPEED_DEADBAND))
    else $error("speed inside deadband not forced to zero");

  // output state is never left without loading a result
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdss_pkg::ST_OUT && state_d == tdss_pkg::ST_IDLE) |=> out_valid_o)
    else $error("output state left without a result");

endmodule

// ===== tb/tank_drive_setpoint_shaper_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_drive_setpoint_shaper_unit_tb
// Sends joystick beats through the setpoint shaper with random flow control
// on both channels, predicts each output beat with an untimed model of the
// cube, mix, low-pass and scaling arithmetic, and compares field by field.
// ----------------------------------------------------------------------------
module tank_drive_setpoint_shaper_unit_tb;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     HOLD_CYCLES    = 150;
  localparam int     RAND_PHASES    = 6;
  localparam int     PHASE_BEATS    = 100;
  localparam longint DEADBAND_Q816  = 3277;
  localparam longint FILT_MAX       = 64'hFFFFFF;
  localparam longint SP_LO          = -65536;
  localparam longint SP_HI          = 65535;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        gear;
  } stick_beat_t;

  typedef struct packed {
    logic [16:0] left;
    logic [16:0] right;
    logic        up;
    logic        down;
  } wheel_cmd_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [1:0]         cfg_idx    = tdss_pkg::REG_TURN_SCALE;
  logic [15:0]        cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [15:0]        left_stick  = '0;
  logic [15:0]        right_stick = '0;
  logic               high_gear  = 1'b0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [16:0] left_sp;
  logic signed [16:0] right_sp;
  logic               shift_up;
  logic               shift_down;

  // shaper state and register copies
  longint turn_gain  = 16384;
  longint lp_coef    = 6554;
  longint top_hi     = 0;
  longint top_lo     = 0;
  longint filt_speed = 0;

  stick_beat_t stick_q[$];
  wheel_cmd_t  wheel_expect_q[$];
  stick_beat_t cur_beat;
  wheel_cmd_t  wheel_want;

  // flow control
  logic idle_en   = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   in_gap    = 0;
  int   out_gap   = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatch_cnt = 0;

  tank_drive_setpoint_shaper_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .left_stick_i     (left_stick),
    .right_stick_i    (right_stick),
    .high_gear_i      (high_gear),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .left_setpoint_o  (left_sp),
    .right_setpoint_o (right_sp),
    .shift_up_o       (shift_up),
    .shift_down_o     (shift_down)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Q1.15 cube, rounded half up
  function automatic longint cube_q15(input longint s);
    return (s * s * s + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // mean plus or minus scaled difference, exact at Q.30 then back to Q1.15
  function automatic longint mix_q15(input longint a, input longint b, input bit add);
    longint mean;
    longint diff;
    longint v;
    mean = (a + b) * 16384;
    diff = 2 * (a - b) * turn_gain;
    v = add ? mean + diff : mean - diff;
    return clamp((v + 16384) >>> 15, -32768, 32767);
  endfunction

  // one joystick beat to one wheel command; advances the speed filter
  function automatic wheel_cmd_t shape_sample(input stick_beat_t b);
    longint ls, rs, cl, cr, ml, mr, tgt, spd, lt, rt;
    wheel_cmd_t r;
    ls = longint'($signed(b.left));
    rs = longint'($signed(b.right));
    cl = cube_q15(ls);
    cr = cube_q15(rs);
    ml = mix_q15(cl, cr, 1'b1);
    mr = mix_q15(cl, cr, 1'b0);
    tgt = (b.gear ? top_hi : top_lo) * 256;
    filt_speed = filt_speed + (((tgt - filt_speed) * lp_coef + 32768) >>> 16);
    filt_speed = clamp(filt_speed, 0, FILT_MAX);
    spd = (filt_speed < DEADBAND_Q816) ? 0 : filt_speed;
    lt = (ml * spd + (64'sd1 <<< 22)) >>> 23;
    rt = (mr * spd + (64'sd1 <<< 22)) >>> 23;
    lt = clamp(lt, SP_LO, SP_HI);
    rt = clamp(-rt, SP_LO, SP_HI);
    r.left  = lt[16:0];
    r.right = rt[16:0];
    r.up    = b.gear;
    r.down  = ~b.gear;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tdss_pkg::REG_TURN_SCALE:  turn_gain = longint'(val);
      tdss_pkg::REG_SPEED_ALPHA: lp_coef   = longint'(val);
      tdss_pkg::REG_HIGH_SPEED:  top_hi    = longint'(val);
      tdss_pkg::REG_LOW_SPEED:   top_lo    = longint'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] ts, input logic [15:0] al,
                           input logic [15:0] hi, input logic [15:0] lo);
    write_reg(tdss_pkg::REG_TURN_SCALE, ts);
    write_reg(tdss_pkg::REG_SPEED_ALPHA, al);
    write_reg(tdss_pkg::REG_HIGH_SPEED, hi);
    write_reg(tdss_pkg::REG_LOW_SPEED, lo);
  endtask

  task automatic queue_beat(input logic [15:0] l, input logic [15:0] r, input logic g);
    stick_beat_t b;
    b.left  = l;
    b.right = r;
    b.gear  = g;
    stick_q.push_back(b);
  endtask

  // everything sent and answered, plus some slack
  task automatic wait_drained();
    while (stick_q.size() != 0 || in_valid || wheel_expect_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_stick();
    logic [15:0] s;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: s = 16'h8000;
          1: s = 16'h7FFF;
          2: s = 16'h0000;
          3: s = 16'h0001;
          default: s = 16'hFFFF;
        endcase
      end
      1: s = 16'($urandom_range(0, 1023) - 512);
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [15:0] rand_turn();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = 16'd16384;
      default: v = 16'($urandom_range(0, 40000));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_alpha();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_top();
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: v = 16'h0000;
      1: v = 16'd12;
      2: v = 16'd13;
      3: v = 16'hFFFF;
      4: v = 16'($urandom);
      default: v = 16'($urandom_range(0, 1023));
    endcase
    return v;
  endfunction

  // input side: offers queued beats, predicts each one as it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        wheel_expect_q.push_back(shape_sample(cur_beat));
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (stick_q.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
          in_gap   <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (stick_q.size() != 0) begin
          cur_beat     = stick_q.pop_front();
          left_stick  <= cur_beat.left;
          right_stick <= cur_beat.right;
          high_gear   <= cur_beat.gear;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: checks each taken beat, then picks the next stall value
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (wheel_expect_q.size() == 0) begin
          report_mismatch("unexpected beat, left_setpoint", longint'(left_sp), 64'sd0);
        end else begin
          wheel_want = wheel_expect_q.pop_front();
          if (left_sp !== wheel_want.left)
            report_mismatch("left_setpoint", longint'(left_sp),
                            longint'($signed(wheel_want.left)));
          if (right_sp !== wheel_want.right)
            report_mismatch("right_setpoint", longint'(right_sp),
                            longint'($signed(wheel_want.right)));
          if (shift_up !== wheel_want.up)
            report_mismatch("shift_up", longint'(shift_up), longint'(wheel_want.up));
          if (shift_down !== wheel_want.down)
            report_mismatch("shift_down", longint'(shift_down),
                            longint'(wheel_want.down));
        end
      end
      // long hold-off lets the block back up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_gap   <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with work outstanding and no beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (stick_q.size() != 0 || in_valid || wheel_expect_q.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic g;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    idle_en <= 1'b1;

    // reset registers: zero top speeds give zero setpoints
    queue_beat(16'h7FFF, 16'h8000, 1'b1);
    queue_beat(16'h8000, 16'h7FFF, 1'b0);
    wait_drained();

    // full top speed, stick extremes, setpoint saturation
    write_all(16'd16384, 16'hFFFF, 16'hFFFF, 16'h0100);
    queue_beat(16'h7FFF, 16'h7FFF, 1'b1);
    queue_beat(16'h8000, 16'h8000, 1'b1);
    queue_beat(16'h7FFF, 16'h8000, 1'b1);
    queue_beat(16'h8000, 16'h7FFF, 1'b1);
    queue_beat(16'h0000, 16'h0000, 1'b1);
    queue_beat(16'h0001, 16'hFFFF, 1'b0);
    queue_beat(16'hFFFF, 16'h0001, 1'b0);
    queue_beat(16'h4000, 16'hC000, 1'b0);
    queue_beat(16'h7FFF, 16'h0000, 1'b0);
    queue_beat(16'h0000, 16'h8000, 1'b1);
    wait_drained();

    // large turn gain saturates the mix; low gear drops into the deadband
    write_all(16'hFFFF, 16'hFFFF, 16'h4000, 16'd12);
    queue_beat(16'h7FFF, 16'h8000, 1'b1);
    queue_beat(16'h8000, 16'h7FFF, 1'b1);
    queue_beat(16'h4E20, 16'hEC78, 1'b1);
    queue_beat(16'h6000, 16'h2000, 1'b0);
    queue_beat(16'h6000, 16'h2000, 1'b0);
    queue_beat(16'hA000, 16'hE000, 1'b0);
    wait_drained();

    // just above the deadband, no turn gain
    write_reg(tdss_pkg::REG_LOW_SPEED, 16'd13);
    write_reg(tdss_pkg::REG_TURN_SCALE, 16'h0000);
    queue_beat(16'h6000, 16'h2000, 1'b0);
    queue_beat(16'h7FFF, 16'h7FFF, 1'b0);

    // random phases, each with fresh register values; the last one runs flat out
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      write_all(rand_turn(), rand_alpha(), rand_top(), rand_top());
      idle_en <= (ph != RAND_PHASES - 1);
      if (ph == 1)
        hold_req <= 1'b1;
      g = 1'($urandom);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // gear held over runs so the filter settles between shifts
        if ($urandom_range(0, 7) == 0)
          g = ~g;
        queue_beat(rand_stick(), rand_stick(), g);
      end
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tdss_pkg.sv
design/tdss_lane.sv
design/tdss_speed_filter.sv
design/tdss_merge.sv
design/tank_drive_setpoint_shaper_unit.sv
tb/tank_drive_setpoint_shaper_unit_tb.sv
